@@ hdl/spq_pkg.sv @@
`timescale 1ns / 1ps

package spq_pkg;

  localparam int unsigned DEPTH     = 16;
  localparam int unsigned TIME_BITS = 16;
  localparam int unsigned PROC_BITS = 8;
  localparam int unsigned CNT_BITS  = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_POP    = 2'd1,
    REQ_PEEK   = 2'd2
  } req_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef struct packed {
    logic [TIME_BITS-1:0] entry_time;
    logic [PROC_BITS-1:0] entry_proc;
  } spq_entry_t;

  typedef struct packed {
    logic [1:0]           req_type;
    logic [TIME_BITS-1:0] entry_time;
    logic [PROC_BITS-1:0] entry_proc;
  } spq_in_t;

  typedef struct packed {
    logic [TIME_BITS-1:0] head_time;
    logic [PROC_BITS-1:0] head_proc;
    logic [CNT_BITS-1:0]  entry_count;
    logic [1:0]           status;
  } spq_out_t;

  // Per-cell control from the top level
  typedef struct packed {
    logic shift_in;   // insert: open a slot and shift toward the tail
    logic shift_out;  // pop: move every entry one place toward the head
    logic occupied;   // this cell holds a stored entry
  } spq_ctrl_t;

endpackage

@@ hdl/spq_cell.sv @@
`timescale 1ns / 1ps

module spq_cell import spq_pkg::*; (
  input  logic       clk_i,
  input  spq_ctrl_t  ctrl_i,
  input  spq_entry_t new_i,
  input  logic       prev_lt_i,
  input  spq_entry_t prev_entry_i,
  input  spq_entry_t next_entry_i,
  output spq_entry_t entry_o,
  output logic       lt_o
);

  spq_entry_t entry_q;
  spq_entry_t entry_d;

  // New item goes before this cell: an empty cell counts as the largest key.
  // Equal keys compare false, so the new item lands behind them.
  assign lt_o = !ctrl_i.occupied
             || (new_i.entry_time < entry_q.entry_time)
             || ((new_i.entry_time == entry_q.entry_time)
                 && (new_i.entry_proc < entry_q.entry_proc));

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.shift_in) begin
      if (prev_lt_i) begin
        entry_d = prev_entry_i;
      end else if (lt_o) begin
        entry_d = new_i;
      end
    end else if (ctrl_i.shift_out) begin
      entry_d = next_entry_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

@@ hdl/sorted_priority_queue.sv @@
`timescale 1ns / 1ps

// Sorted priority queue of (time, proc) items held in a chain of DEPTH cells,
// head in cell 0. Every request (insert, pop, peek; code 3 acts as peek) yields
// one result item with the head, the count after the request and a status.
// One request is taken per clock cycle unless the input is stalled: all cells
// compare the new item against their own entry in the same cycle, and entries
// move one place at the next edge. The result sits in an output register, valid
// in the cycle after its request; while it is stalled, so is the input.
module sorted_priority_queue import spq_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  spq_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output spq_out_t out_data_o
);

  logic [CNT_BITS-1:0] count_q, count_d;
  logic                out_valid_q, out_valid_d;
  spq_out_t            out_data_q, out_data_d;

  logic       accept;
  logic       full, empty;
  spq_entry_t new_entry;
  spq_entry_t entry_w [DEPTH];
  logic       lt_w    [DEPTH];
  logic       do_insert, do_pop;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign full       = (count_q == CNT_BITS'(DEPTH));
  assign empty      = (count_q == '0);

  assign new_entry.entry_time = in_data_i.entry_time;
  assign new_entry.entry_proc = in_data_i.entry_proc;

  assign do_insert = accept && (in_data_i.req_type == REQ_INSERT) && !full;
  assign do_pop    = accept && (in_data_i.req_type == REQ_POP) && !empty;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    spq_ctrl_t  ctrl;
    logic       prev_lt;
    spq_entry_t prev_entry;
    spq_entry_t next_entry;

    assign ctrl.shift_in  = do_insert;
    assign ctrl.shift_out = do_pop;
    assign ctrl.occupied  = (CNT_BITS'(i) < count_q);

    if (i == 0) begin : g_head
      assign prev_lt    = 1'b0;
      assign prev_entry = '0;
    end else begin : g_body
      assign prev_lt    = lt_w[i-1];
      assign prev_entry = entry_w[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign next_entry = '0;
    end else begin : g_mid
      assign next_entry = entry_w[i+1];
    end

    spq_cell u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl),
      .new_i        (new_entry),
      .prev_lt_i    (prev_lt),
      .prev_entry_i (prev_entry),
      .next_entry_i (next_entry),
      .entry_o      (entry_w[i]),
      .lt_o         (lt_w[i])
    );
  end

  always_comb begin
    count_d     = count_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_data_d  = out_data_q;
    if (accept) begin
      out_valid_d            = 1'b1;
      out_data_d.head_time   = entry_w[0].entry_time;
      out_data_d.head_proc   = entry_w[0].entry_proc;
      out_data_d.entry_count = count_q;
      out_data_d.status      = ST_OK;
      case (in_data_i.req_type)
        REQ_INSERT: begin
          if (full) begin
            out_data_d.status = ST_FULL;
          end else begin
            count_d                = count_q + 1'b1;
            out_data_d.entry_count = count_q + 1'b1;
            if (lt_w[0]) begin
              out_data_d.head_time = new_entry.entry_time;
              out_data_d.head_proc = new_entry.entry_proc;
            end
          end
        end
        REQ_POP: begin
          if (!empty) begin
            count_d                = count_q - 1'b1;
            out_data_d.entry_count = count_q - 1'b1;
          end
        end
        default: ;
      endcase
      // Pop or peek on an empty queue
      if ((in_data_i.req_type != REQ_INSERT) && empty) begin
        out_data_d.head_time = '0;
        out_data_d.head_proc = '0;
        out_data_d.status    = ST_EMPTY;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule
